// File: hdl/dcs_pkg.sv
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared constants, codes and types of the distance constraint solver.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int MaxParticles  = 1024;
  localparam int IdxW          = $clog2(MaxParticles);
  localparam int CollapseLimit = 1;

  localparam logic [16:0] OneQ16  = 17'h10000;
  localparam logic [16:0] HalfQ16 = 17'h08000;

  // serial divider widths: |k * (len - rest)| over len
  localparam int DivNW = 49;
  localparam int DivDW = 32;

  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActSolve = 2'd1,
    ActWeld  = 2'd2,
    ActRead  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StRange    = 2'd1,
    StCollapse = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CfgStretch  = 3'd0,
    CfgCompress = 3'd1,
    CfgBlend    = 3'd2,
    CfgLocked   = 3'd3,
    CfgCount    = 3'd4
  } cfg_e;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  function automatic logic [16:0] clamp_q16(input logic [16:0] v);
    return (v > OneQ16) ? OneQ16 : v;
  endfunction

endpackage

// File: hdl/dcs_div.sv
// ----------------------------------------------------------------------------
// dcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dcs_pkg::div_req_t          req_i,
  output logic                       done_o,
  output logic [dcs_pkg::DivNW-1:0]  quot_o
);
  import dcs_pkg::*;

  localparam int CntW = $clog2(DivNW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivNW-1:0] num_q, num_d;
  logic [DivDW-1:0] rem_q, rem_d;
  logic [DivDW-1:0] dvs_q, dvs_d;
  logic [DivDW:0]   sh;
  logic             ge;

  assign sh = {rem_q, num_q[DivNW-1]};
  assign ge = sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? DivDW'(sh - {1'b0, dvs_q}) : sh[DivDW-1:0];
      num_d = {num_q[DivNW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivNW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// File: hdl/distance_constraint_solver_top.sv
// ----------------------------------------------------------------------------
// distance_constraint_solver_top
// Particle position store with a serial distance constraint solver.
// ----------------------------------------------------------------------------
// One item is in work at a time. A solve spends most of its time in the 32-step
// bit-serial square root and in the 49-step restoring divider; a collapsed edge
// ends before the divider. The position store is one 1024 x 96 memory with
// a single read port and a single write port. The next item is taken while the
// previous result still waits on the output.
module distance_constraint_solver_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // index_a, index_b, load_x, load_y, load_z, rest_length, symmetric, pad
  input  logic [151:0] s_axis_tdata,
  // action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_x, read_y, read_z
  output logic [95:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [16:0]  cfg_data_i
);
  import dcs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0,  S_LOAD = 4'd1,  S_RA   = 4'd2,  S_RB   = 4'd3,
                         S_CB   = 4'd4,  S_SQ   = 4'd5,  S_SQRT = 4'd6,  S_KD   = 4'd7,
                         S_DIVS = 4'd8,  S_DIVW = 4'd9,  S_CORR = 4'd10, S_MOV  = 4'd11,
                         S_WR   = 4'd12, S_WELD = 4'd13, S_READ = 4'd14, S_FIN  = 4'd15;

  // configuration
  logic [16:0] stretch_q, compress_q, blend_q;
  logic [10:0] locked_q, count_q;

  // item
  logic [3:0]        state_q;
  action_e           act_q;
  logic [IdxW-1:0]   ia_q, ib_q;
  logic [95:0]       ld_q;
  logic [30:0]       rest_q;
  logic              sym_q;
  logic              side_q;
  logic [4:0]        cnt_q;

  // datapath
  logic signed [31:0] pa_q [3];
  logic signed [31:0] pb_q [3];
  logic signed [31:0] d_q [3];
  logic signed [47:0] corr_q [3];
  logic signed [31:0] new_q [3];
  logic [63:0]        sq_q, acc_q, acc_sum;
  logic [33:0]        rem_q;
  logic [31:0]        root_q;
  logic signed [51:0] num_q;
  logic signed [31:0] f_q;
  logic signed [63:0] prod_q;
  logic signed [65:0] mp_q;
  logic signed [31:0] psel_q;

  // output
  logic        m_valid_q;
  logic [95:0] res_q, m_data_q;
  status_e     status_q;
  logic [1:0]  m_user_q;

  // memory
  logic [95:0]     mem [MaxParticles];
  logic [95:0]     rdata_q;
  logic [IdxW-1:0] raddr, waddr;
  logic            we;
  logic [95:0]     wdata;

  // divider
  div_req_t         div_req;
  logic             div_done;
  logic [DivNW-1:0] div_quot;

  // input unpack
  logic [IdxW-1:0] in_ia, in_ib;
  logic            ra_ok, rb_ok, s_acc;

  assign in_ia = s_axis_tdata[9:0];
  assign in_ib = s_axis_tdata[19:10];
  assign ra_ok = ({1'b0, in_ia} < count_q) && ({1'b0, in_ia} < 11'(MaxParticles));
  assign rb_ok = ({1'b0, in_ib} < count_q) && ({1'b0, in_ib} < 11'(MaxParticles));
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stretch_q  <= OneQ16;
      compress_q <= OneQ16;
      blend_q    <= HalfQ16;
      locked_q   <= '0;
      count_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStretch:  stretch_q  <= cfg_data_i;
        CfgCompress: compress_q <= cfg_data_i;
        CfgBlend:    blend_q    <= cfg_data_i;
        CfgLocked:   locked_q   <= cfg_data_i[10:0];
        CfgCount:    count_q    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // memory ports
  assign raddr = (state_q == S_RB) ? ib_q : ia_q;

  always_comb begin
    we    = 1'b0;
    waddr = ia_q;
    wdata = ld_q;
    unique case (state_q)
      S_LOAD: we = 1'b1;
      S_WELD: begin
        we    = 1'b1;
        waddr = ib_q;
        wdata = rdata_q;
      end
      S_WR: begin
        waddr = side_q ? ib_q : ia_q;
        we    = {1'b0, waddr} >= locked_q;
        wdata = {new_q[2], new_q[1], new_q[0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // arithmetic helpers
  logic [31:0]        dabs;
  logic [63:0]        sq_d;
  logic [35:0]        sqrt_sh, sqrt_trial;
  logic               sqrt_ge;
  logic [16:0]        k_sel, w_sel;
  logic signed [33:0] diff;
  logic signed [47:0] corr_d;
  logic signed [49:0] mv;
  logic signed [50:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [32:0] dsub [3];
  logic signed [31:0] dsat [3];
  logic [DivNW-1:0]   num_abs;
  logic signed [31:0] f_d;

  assign dabs    = d_q[0][31] ? 32'(-d_q[0]) : d_q[0];
  assign sq_d    = dabs * dabs;
  assign acc_sum = acc_q + sq_q;

  assign sqrt_sh    = {rem_q, acc_q[63:62]};
  assign sqrt_trial = {2'b00, root_q, 2'b01};
  assign sqrt_ge    = sqrt_sh >= sqrt_trial;

  assign k_sel = (root_q > {1'b0, rest_q}) ? clamp_q16(stretch_q) : clamp_q16(compress_q);
  assign diff  = $signed({2'b00, root_q}) - $signed({3'b000, rest_q});
  assign w_sel = sym_q ? HalfQ16 : (side_q ? clamp_q16(blend_q) : 17'(OneQ16 - clamp_q16(blend_q)));

  assign corr_d = 48'((prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0)) >>> 16);
  assign mv     = 50'((mp_q + (mp_q[65] ? 66'sd65535 : 66'sd0)) >>> 16);
  assign pos_sum = side_q ? (51'(psel_q) - 51'(mv)) : (51'(psel_q) + 51'(mv));
  assign pos_sat = (pos_sum > 51'sd2147483647)  ? 32'sh7fffffff :
                   (pos_sum < -51'sd2147483648) ? 32'sh80000000 : 32'(pos_sum);

  for (genvar c = 0; c < 3; c++) begin : g_edge
    assign dsub[c] = 33'($signed(rdata_q[32*c +: 32])) - 33'(pa_q[c]);
    assign dsat[c] = (dsub[c] > 33'sd2147483647)  ? 32'sh7fffffff :
                     (dsub[c] < -33'sd2147483648) ? 32'sh80000000 : 32'(dsub[c]);
  end

  assign num_abs = num_q[51] ? DivNW'(-num_q) : DivNW'(num_q);
  always_comb begin
    if (num_q[51]) f_d = (div_quot > DivNW'(32'h80000000)) ? 32'sh80000000
                                                          : 32'(-$signed({1'b0, div_quot}));
    else           f_d = (div_quot > DivNW'(32'h7fffffff)) ? 32'sh7fffffff : 32'(div_quot);
  end

  assign div_req.start    = (state_q == S_DIVS);
  assign div_req.dividend = num_abs;
  assign div_req.divisor  = root_q;

  dcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
      side_q    <= 1'b0;
    end else begin
      if (state_q == S_FIN && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (s_acc) begin
          if (!ra_ok || ((action_e'(s_axis_tuser) == ActSolve ||
                          action_e'(s_axis_tuser) == ActWeld) && !rb_ok)) begin
            state_q <= S_FIN;
          end else if (action_e'(s_axis_tuser) == ActLoad) begin
            state_q <= S_LOAD;
          end else begin
            state_q <= S_RA;
          end
        end
        S_LOAD: state_q <= S_FIN;
        S_RA: begin
          unique case (act_q)
            ActRead: state_q <= S_READ;
            ActWeld: state_q <= S_WELD;
            default: state_q <= S_RB;
          endcase
        end
        S_READ, S_WELD: state_q <= S_FIN;
        S_RB: state_q <= S_CB;
        S_CB: begin
          cnt_q   <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (cnt_q == 5'd3) begin
            cnt_q   <= '0;
            state_q <= (acc_sum < 64'(CollapseLimit)) ? S_FIN : S_SQRT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd31) state_q <= S_KD;
        end
        S_KD: state_q <= (root_q == '0) ? S_FIN : S_DIVS;
        S_DIVS: state_q <= S_DIVW;
        S_DIVW: if (div_done) begin
          cnt_q   <= '0;
          state_q <= S_CORR;
        end
        S_CORR: begin
          if (cnt_q == 5'd3) begin
            cnt_q   <= '0;
            side_q  <= 1'b0;
            state_q <= S_MOV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MOV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd3) state_q <= S_WR;
        end
        S_WR: begin
          cnt_q <= '0;
          if (!side_q) begin
            side_q  <= 1'b1;
            state_q <= S_MOV;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: if (!m_valid_q || m_axis_tready) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (s_acc) begin
        act_q    <= action_e'(s_axis_tuser);
        ia_q     <= in_ia;
        ib_q     <= in_ib;
        ld_q     <= s_axis_tdata[115:20];
        rest_q   <= s_axis_tdata[146:116];
        sym_q    <= s_axis_tdata[147];
        res_q    <= '0;
        acc_q    <= '0;
        rem_q    <= '0;
        root_q   <= '0;
        status_q <= (!ra_ok || ((action_e'(s_axis_tuser) == ActSolve ||
                                 action_e'(s_axis_tuser) == ActWeld) && !rb_ok))
                    ? StRange : StDone;
      end
      S_READ: res_q <= rdata_q;
      S_RB: for (int c = 0; c < 3; c++) pa_q[c] <= $signed(rdata_q[32*c +: 32]);
      S_CB: begin
        for (int c = 0; c < 3; c++) begin
          pb_q[c] <= $signed(rdata_q[32*c +: 32]);
          d_q[c]  <= dsat[c];
        end
      end
      S_SQ: begin
        if (cnt_q < 5'd3) begin
          sq_q <= sq_d;
          d_q  <= '{d_q[1], d_q[2], d_q[0]};
        end
        if (cnt_q != 5'd0) acc_q <= acc_sum;
        if (cnt_q == 5'd3 && acc_sum < 64'(CollapseLimit)) status_q <= StCollapse;
      end
      S_SQRT: begin
        rem_q  <= sqrt_ge ? 34'(sqrt_sh - sqrt_trial) : sqrt_sh[33:0];
        root_q <= {root_q[30:0], sqrt_ge};
        acc_q  <= {acc_q[61:0], 2'b00};
      end
      S_KD: begin
        num_q <= $signed({1'b0, k_sel}) * diff;
        if (root_q == '0) status_q <= StCollapse;
      end
      S_DIVW: if (div_done) f_q <= f_d;
      S_CORR: begin
        if (cnt_q < 5'd3) begin
          prod_q <= d_q[0] * f_q;
          d_q    <= '{d_q[1], d_q[2], d_q[0]};
        end
        if (cnt_q != 5'd0) corr_q <= '{corr_q[1], corr_q[2], corr_d};
      end
      S_MOV: begin
        if (cnt_q < 5'd3) begin
          mp_q   <= corr_q[0] * $signed({1'b0, w_sel});
          psel_q <= side_q ? pb_q[0] : pa_q[0];
          corr_q <= '{corr_q[1], corr_q[2], corr_q[0]};
          if (side_q) pb_q <= '{pb_q[1], pb_q[2], pb_q[0]};
          else        pa_q <= '{pa_q[1], pa_q[2], pa_q[0]};
        end
        if (cnt_q != 5'd0) new_q <= '{new_q[1], new_q[2], pos_sat};
      end
      default: ;
    endcase
    if (state_q == S_FIN && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= res_q;
      m_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != StDone |-> m_axis_tdata == '0)
    else $error("nonzero data on failed item");

endmodule
